>>> design/ths_pkg.sv
package ths_pkg;
    typedef enum logic [1:0] {
        FUNC_SCHED  = 2'd0,
        FUNC_CANCEL = 2'd1,
        FUNC_CHECK  = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    localparam int unsigned MAX_FIRED  = 63;
    localparam int unsigned CNT_BITS   = 16;
    localparam int unsigned FCNT_BITS  = 6;
    localparam int unsigned OUT_ID_BITS = 16;
endpackage

>>> design/timer_heap_scheduler.sv
// Timer queue held as a binary min-heap in one synchronous memory.
// Input channel (i_valid/o_ready) carries one operation per transfer:
//   schedule inserts id/interval/repeat count and answers one status result;
//   cancel scans slots in order, disables the first id match, answers one
//   status result; check pops due entries, gives one fired result per enabled
//   timer (re-armed at now + interval while firings remain) and a final
//   result with the fired count. Unknown operations answer ok.
// Output channel (o_valid/i_ready) carries one result per transfer; a result
// waits in the output register while the receiver stalls, and the engine
// waits with it. The engine handles one operation at a time.
// Schedule sifts the new entry up the heap level by level; cancel scans the
// live slots one by one; check sifts the tail entry down level by level for
// each popped entry and sifts a re-armed entry back up. All steps go through
// the single read port of the heap memory (one access per cycle, registered
// read data).
// Reset empties the heap (length zero); slot contents need no clearing since
// nothing beyond the live length is ever read.
module timer_heap_scheduler
    import ths_pkg::*;
#(
    parameter int QUEUE_SLOTS = 64,
    parameter int TIME_BITS   = 32,
    parameter int ID_BITS     = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_func,
    input  logic [TIME_BITS-1:0]   i_now_time,
    input  logic [ID_BITS-1:0]     i_timer_id,
    input  logic [TIME_BITS-1:0]   i_interval,
    input  logic [CNT_BITS-1:0]    i_repeat_count,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_kind,
    output logic [OUT_ID_BITS-1:0] o_fired_id,
    output logic [1:0]             o_status,
    output logic [FCNT_BITS-1:0]   o_fired_count,
    output logic                   o_last
);
    localparam int AW = $clog2(QUEUE_SLOTS);
    localparam logic [AW:0] CAP = (AW+1)'(QUEUE_SLOTS - 1);
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    typedef struct packed {
        logic [TIME_BITS-1:0] expiry;
        logic [TIME_BITS-1:0] period;
        logic                 en;
        logic [CNT_BITS-1:0]  cnt;
        logic [ID_BITS-1:0]   id;
    } t_ent;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_CAN_RD, S_CAN_CMP,
        S_CHK_RD, S_CHK_TOP, S_POP_RDL, S_POP_LAST, S_POP_RDC1,
        S_POP_RDC2, S_POP_CMP, S_OUT, S_DONE
    } t_state;

    // heap memory, one read port, one write port
    t_ent mem [QUEUE_SLOTS];
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    t_ent          mem_wd, r_rd;
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    t_state r_state, n_state;
    logic [AW:0] r_len, n_len;
    logic [AW:0] r_pos, n_pos;       // hole / parent / scan index
    logic [AW:0] r_ch, n_ch;         // child index
    t_ent r_new, n_new;              // entry being placed
    t_ent r_c1, n_c1;                // first child
    t_ent r_top, n_top;              // popped top
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [FCNT_BITS-1:0] r_n, n_n;
    logic r_ins_after, n_ins_after;  // pop followed by re-arm insert
    logic r_ov, n_ov;
    logic [1:0] r_kind, n_kind, r_st, n_st;
    logic [OUT_ID_BITS-1:0] r_fid, n_fid;
    logic [FCNT_BITS-1:0] r_fc, n_fc;
    logic r_last, n_last;
    t_state r_ret, n_ret;            // state after the result is loaded into the output register

    function automatic logic [TIME_BITS-1:0] sat_add(
        input logic [TIME_BITS-1:0] a, input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
    endfunction

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ov;
    assign o_kind        = r_kind;
    assign o_status      = r_st;
    assign o_fired_id    = r_fid;
    assign o_fired_count = r_fc;
    assign o_last        = r_last;

    always_comb begin
        logic [AW:0] par;
        logic [AW:0] nl;
        n_state = r_state; n_len = r_len; n_pos = r_pos; n_ch = r_ch;
        n_new = r_new; n_c1 = r_c1; n_top = r_top;
        n_now = r_now; n_id = r_id; n_n = r_n; n_ins_after = r_ins_after;
        n_ov = r_ov; n_kind = r_kind; n_st = r_st; n_fid = r_fid;
        n_fc = r_fc; n_last = r_last; n_ret = r_ret;
        mem_we = 1'b0; mem_wa = '0; mem_wd = r_new; mem_ra = '0;
        par = r_pos >> 1;
        nl = '0;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                n_now = i_now_time; n_id = i_timer_id;
                n_new.expiry = sat_add(i_now_time, i_interval);
                n_new.period = i_interval;
                n_new.en = 1'b1; n_new.cnt = i_repeat_count; n_new.id = i_timer_id;
                n_kind = KIND_STATUS; n_st = ST_OK; n_fid = '0; n_fc = '0;
                n_last = 1'b1; n_n = '0; n_ret = S_DONE;
                unique case (i_func)
                    FUNC_SCHED: if (r_len >= CAP) begin
                        n_st = ST_FULL; n_state = S_OUT;
                    end else begin
                        n_len = r_len + 1'b1; n_pos = r_len + 1'b1;
                        n_state = S_INS_RD;
                    end
                    FUNC_CANCEL: begin
                        n_pos = (AW+1)'(1); n_state = S_CAN_RD;
                    end
                    FUNC_CHECK: n_state = S_CHK_RD;
                    default: n_state = S_OUT;
                endcase
            end
            S_INS_RD: begin
                if (r_pos <= (AW+1)'(1)) begin
                    mem_we = 1'b1; mem_wa = r_pos[AW-1:0]; mem_wd = r_new;
                    n_state = r_ins_after ? S_CHK_RD : S_OUT;
                    n_ins_after = 1'b0;
                end else begin
                    mem_ra = par[AW-1:0]; n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (r_rd.expiry > r_new.expiry) begin
                    mem_we = 1'b1; mem_wa = r_pos[AW-1:0]; mem_wd = r_rd;
                    n_pos = par; n_state = S_INS_RD;
                end else begin
                    mem_we = 1'b1; mem_wa = r_pos[AW-1:0]; mem_wd = r_new;
                    n_state = r_ins_after ? S_CHK_RD : S_OUT;
                    n_ins_after = 1'b0;
                end
            end
            S_CAN_RD: begin
                if (r_pos > r_len) begin
                    n_st = ST_NOT_FOUND; n_state = S_OUT;
                end else begin
                    mem_ra = r_pos[AW-1:0]; n_state = S_CAN_CMP;
                end
            end
            S_CAN_CMP: begin
                if (r_rd.id == r_id) begin
                    mem_we = 1'b1; mem_wa = r_pos[AW-1:0];
                    mem_wd = r_rd; mem_wd.en = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_pos = r_pos + 1'b1; n_state = S_CAN_RD;
                end
            end
            S_CHK_RD: begin
                // a fired result still waiting holds the output register
                if (r_ov && !i_ready) begin
                    n_state = S_CHK_RD;
                end else if (r_n >= FCNT_BITS'(MAX_FIRED) || r_len == '0) begin
                    n_kind = KIND_DONE; n_fc = r_n; n_last = 1'b1; n_fid = '0;
                    n_st = ST_OK; n_ret = S_DONE; n_state = S_OUT;
                end else begin
                    mem_ra = AW'(1); n_state = S_CHK_TOP;
                end
            end
            S_CHK_TOP: begin
                if (r_rd.expiry > r_now) begin
                    n_kind = KIND_DONE; n_fc = r_n; n_last = 1'b1; n_fid = '0;
                    n_st = ST_OK; n_ret = S_DONE; n_state = S_OUT;
                end else begin
                    n_top = r_rd; mem_ra = r_len[AW-1:0];
                    n_state = S_POP_RDL;
                end
            end
            S_POP_RDL: begin
                n_new = r_rd;
                nl = r_len - 1'b1;
                n_len = nl;
                n_pos = (AW+1)'(1); n_ch = (AW+1)'(2);
                n_state = S_POP_RDC1;
            end
            S_POP_RDC1: begin
                if (r_ch > r_len) begin
                    mem_we = (r_len != '0); mem_wa = r_pos[AW-1:0]; mem_wd = r_new;
                    n_state = S_POP_LAST;
                end else begin
                    mem_ra = r_ch[AW-1:0]; n_state = S_POP_RDC2;
                end
            end
            S_POP_RDC2: begin
                n_c1 = r_rd;
                if (r_ch < r_len) begin
                    mem_ra = AW'(r_ch + 1'b1); n_state = S_POP_CMP;
                end else begin
                    if (r_new.expiry <= r_rd.expiry) begin
                        mem_we = 1'b1; mem_wa = r_pos[AW-1:0]; mem_wd = r_new;
                        n_state = S_POP_LAST;
                    end else begin
                        mem_we = 1'b1; mem_wa = r_pos[AW-1:0]; mem_wd = r_rd;
                        n_pos = r_ch; n_ch = {r_ch[AW-1:0], 1'b0};
                        n_state = S_POP_RDC1;
                    end
                end
            end
            S_POP_CMP: begin
                t_ent c;
                logic [AW:0] ci;
                c = r_c1; ci = r_ch;
                if (r_c1.expiry > r_rd.expiry) begin
                    c = r_rd; ci = r_ch + 1'b1;
                end
                if (r_new.expiry <= c.expiry) begin
                    mem_we = 1'b1; mem_wa = r_pos[AW-1:0]; mem_wd = r_new;
                    n_state = S_POP_LAST;
                end else begin
                    mem_we = 1'b1; mem_wa = r_pos[AW-1:0]; mem_wd = c;
                    n_pos = ci; n_ch = {ci[AW-1:0], 1'b0};
                    n_state = S_POP_RDC1;
                end
            end
            S_POP_LAST: begin
                // popped entry now in r_top
                if (!r_top.en) begin
                    n_state = S_CHK_RD;
                end else begin
                    n_n = r_n + 1'b1;
                    n_kind = KIND_FIRED; n_fid = OUT_ID_BITS'(r_top.id);
                    n_st = ST_OK; n_fc = r_n + 1'b1; n_last = 1'b0;
                    n_new = r_top;
                    n_new.expiry = sat_add(r_now, r_top.period);
                    if (r_top.cnt != '0) n_new.cnt = r_top.cnt - 1'b1;
                    if (r_top.cnt == CNT_BITS'(1)) begin
                        n_ret = S_CHK_RD;
                    end else begin
                        n_len = r_len + 1'b1; n_pos = r_len + 1'b1;
                        n_ins_after = 1'b1; n_ret = S_INS_RD;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: if (!r_ov) begin
                n_ov = 1'b1; n_state = r_ret;
            end
            S_DONE: if (!r_ov || i_ready) n_state = r_ov ? S_IDLE : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_len <= '0; r_ov <= 1'b0;
            r_ins_after <= 1'b0; r_ret <= S_DONE;
        end else begin
            r_state <= n_state; r_len <= n_len; r_ov <= n_ov;
            r_ins_after <= n_ins_after; r_ret <= n_ret;
        end
        r_pos <= n_pos; r_ch <= n_ch; r_new <= n_new; r_c1 <= n_c1;
        r_top <= n_top; r_now <= n_now; r_id <= n_id;
        r_n <= n_n; r_kind <= n_kind; r_st <= n_st; r_fid <= n_fid;
        r_fc <= n_fc; r_last <= n_last;
    end

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CAP) else $error("heap length beyond capacity");
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(r_ov && !r_last)) else $error("partial item at idle");
    a_fired_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_kind == KIND_FIRED) |-> !r_last) else $error("fired result marked last");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable({r_kind, r_fid, r_st, r_fc, r_last})))
        else $error("result changed while stalled");
endmodule

>>> tb/timer_heap_scheduler_tb.sv
module timer_heap_scheduler_tb;
    import ths_pkg::*;

    localparam int SLOTS       = 64;
    localparam int CAPACITY    = SLOTS - 1;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int HOLD_AT     = 2500;   // cycle at which the long receiver hold starts
    localparam int HOLD_LEN    = 800;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef struct {
        logic [31:0] expiry;
        logic [31:0] period;
        logic [15:0] id;
        logic [15:0] left;   // firings remaining, 0 = forever
        bit          en;
    } t_timer_slot;

    typedef struct {
        logic [1:0] kind;
        logic [15:0] id;
        logic [1:0] status;
        logic [5:0] count;
        logic       last;
    } t_timer_result;

    // Scoreboard: a private copy of the heap plus the results still owed.
    class timer_scoreboard;
        t_timer_slot   heap[SLOTS];
        int unsigned   length;
        t_timer_result owed[$];
        int            errors;

        function new();
            length = 0;
            errors = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? TIME_MAX : s[31:0];
        endfunction

        function void owe(logic [1:0] k, logic [15:0] id, logic [1:0] st,
                          int cnt, logic lst);
            t_timer_result r;
            r.kind = k; r.id = id; r.status = st; r.count = cnt[5:0]; r.last = lst;
            owed.push_back(r);
        endfunction

        function void sift_in(t_timer_slot e);
            int unsigned child, parent;
            length++;
            child = length;
            parent = child / 2;
            while (parent >= 1 && heap[parent].expiry > e.expiry) begin
                heap[child] = heap[parent];
                child = parent;
                parent = child / 2;
            end
            heap[child] = e;
        endfunction

        function void pop_top();
            t_timer_slot tail;
            int unsigned parent, child;
            tail = heap[length];
            length--;
            parent = 1;
            child = 2;
            while (child <= length) begin
                if (child < length && heap[child].expiry > heap[child + 1].expiry)
                    child++;
                if (tail.expiry <= heap[child].expiry)
                    break;
                heap[parent] = heap[child];
                parent = child;
                child = parent * 2;
            end
            heap[parent] = tail;
        endfunction

        // Work out every result that one accepted operation causes.
        function void note_item(logic [1:0] f, logic [31:0] now, logic [15:0] id,
                                logic [31:0] ival, logic [15:0] reps);
            t_timer_slot e;
            int n;
            bit hit;
            case (f)
                FUNC_SCHED: begin
                    if (length >= CAPACITY) begin
                        owe(KIND_STATUS, 0, ST_FULL, 0, 1'b1);
                    end else begin
                        e.expiry = sat_add(now, ival);
                        e.period = ival;
                        e.id = id;
                        e.left = reps;
                        e.en = 1'b1;
                        sift_in(e);
                        owe(KIND_STATUS, 0, ST_OK, 0, 1'b1);
                    end
                end
                FUNC_CANCEL: begin
                    hit = 0;
                    for (int unsigned i = 1; i <= length && !hit; i++) begin
                        if (heap[i].id == id) begin
                            heap[i].en = 1'b0;
                            hit = 1;
                        end
                    end
                    owe(KIND_STATUS, 0, hit ? ST_OK : ST_NOT_FOUND, 0, 1'b1);
                end
                FUNC_CHECK: begin
                    n = 0;
                    while (n < MAX_FIRED && length >= 1 && heap[1].expiry <= now) begin
                        e = heap[1];
                        pop_top();
                        if (!e.en)
                            continue;
                        n++;
                        owe(KIND_FIRED, e.id, ST_OK, n, 1'b0);
                        if (e.left != 0) begin
                            e.left--;
                            if (e.left == 0)
                                continue;
                        end
                        e.expiry = sat_add(now, e.period);
                        sift_in(e);
                    end
                    owe(KIND_DONE, 0, ST_OK, n, 1'b1);
                end
                default: owe(KIND_STATUS, 0, ST_OK, 0, 1'b1);
            endcase
        endfunction

        function void check_result(logic [1:0] k, logic [15:0] id, logic [1:0] st,
                                   logic [5:0] cnt, logic lst);
            t_timer_result w;
            if (owed.size() == 0) begin
                report($sformatf("result with nothing owed kind=%0d id=%0h", k, id));
                return;
            end
            w = owed.pop_front();
            if (k !== w.kind)
                report($sformatf("kind %0d, want %0d", k, w.kind));
            if (id !== w.id)
                report($sformatf("fired_id %0h, want %0h", id, w.id));
            if (st !== w.status)
                report($sformatf("status %0d, want %0d", st, w.status));
            if (cnt !== w.count)
                report($sformatf("fired_count %0d, want %0d", cnt, w.count));
            if (lst !== w.last)
                report($sformatf("last %0b, want %0b", lst, w.last));
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_func = '0;
    logic [31:0] i_now_time = '0;
    logic [15:0] i_timer_id = '0;
    logic [31:0] i_interval = '0;
    logic [15:0] i_repeat_count = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_kind;
    logic [15:0] o_fired_id;
    logic [1:0]  o_status;
    logic [5:0]  o_fired_count;
    logic        o_last;

    timer_heap_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_now_time(i_now_time), .i_timer_id(i_timer_id),
        .i_interval(i_interval), .i_repeat_count(i_repeat_count),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_fired_id(o_fired_id), .o_status(o_status),
        .o_fired_count(o_fired_count), .o_last(o_last)
    );

    timer_scoreboard sb = new();
    int          cycle = 0;
    int          sent = 0;
    logic [31:0] clock_now = 0;   // running "current time" for the random part

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Cycle counter doubles as the run watchdog.
    initial begin
        forever begin
            @(posedge i_clk);
            cycle++;
            if (cycle >= CYCLE_LIMIT) begin
                $display("timer_heap_scheduler test failed");
                $finish;
            end
        end
    end

    // Gap length: mostly short, a few long; none during back-to-back stretches.
    function automatic int pick_gap();
        int r;
        if ((cycle / 1500) % 4 == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one operation and hold it until the transfer; the scoreboard
    // sees it at the edge where the transfer happens.
    task automatic send_item(logic [1:0] f, logic [31:0] now, logic [15:0] id,
                             logic [31:0] ival, logic [15:0] reps);
        int gap;
        i_valid        <= 1'b1;
        i_func         <= f;
        i_now_time     <= now;
        i_timer_id     <= id;
        i_interval     <= ival;
        i_repeat_count <= reps;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(f, now, id, ival, reps);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver: checks each transfer, stalls at random, plus one long hold
    // so the engine backs up and drops o_ready on the input side.
    initial begin
        int stall;
        stall = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                sb.check_result(o_kind, o_fired_id, o_status, o_fired_count, o_last);
            if (cycle == HOLD_AT)
                stall = HOLD_LEN;
            else if (stall == 0 && (cycle / 1500) % 4 != 1) begin
                case ($urandom_range(0, 19))
                    0, 1: stall = $urandom_range(1, 3);
                    2:    stall = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : 0;
                    default: stall = 0;
                endcase
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] pick_id();
        return ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 15))
                                            : 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [31:0] pick_interval();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) return $urandom_range(0, 60);
        if (r == 8) return $urandom;
        return TIME_MAX - $urandom_range(0, 3);
    endfunction

    function automatic logic [15:0] pick_reps();
        return ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3))
                                          : 16'($urandom_range(0, 65535));
    endfunction

    task automatic advance_time();
        if ($urandom_range(0, 99) < 3)
            clock_now = $urandom;
        else
            clock_now = clock_now + $urandom_range(0, 20);
    endtask

    initial begin
        int pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty check, not found, saturated expiry, repeat counts,
        // double cancel, unknown op, disabled entries dropped; ends empty.
        send_item(FUNC_CHECK,  0, 0, 0, 0);
        send_item(FUNC_CANCEL, 0, 16'd5, 0, 0);
        send_item(FUNC_SCHED,  0, 16'd0, 0, 16'd1);
        send_item(FUNC_SCHED,  TIME_MAX, 16'hFFFF, TIME_MAX, 16'hFFFF);
        send_item(FUNC_SCHED,  0, 16'd7, 32'd10, 16'd2);
        send_item(FUNC_SCHED,  0, 16'd8, 32'd5, 16'd0);
        send_item(FUNC_CANCEL, 0, 16'd8, 0, 0);
        send_item(FUNC_CANCEL, 0, 16'd8, 0, 0);
        send_item(FUNC_NONE,   TIME_MAX, 16'hFFFF, TIME_MAX, 16'hFFFF);
        send_item(FUNC_CHECK,  0, 0, 0, 0);
        send_item(FUNC_CHECK,  32'd10, 0, 0, 0);
        send_item(FUNC_CHECK,  32'd20, 0, 0, 0);
        send_item(FUNC_CANCEL, 0, 16'hFFFF, 0, 0);
        send_item(FUNC_CHECK,  TIME_MAX, 0, 0, 0);

        // Runaway check: fill to capacity with due forever-timers, one more
        // schedule bounces off full, then the check stops at the fired limit.
        clock_now = 32'd1000;
        for (int k = 0; k < CAPACITY; k++)
            send_item(FUNC_SCHED, clock_now, 16'(k), 0, 0);
        send_item(FUNC_SCHED, clock_now, 16'd99, 0, 0);
        send_item(FUNC_CHECK, clock_now, 0, 0, 0);
        for (int k = 0; k < CAPACITY; k++)
            send_item(FUNC_CANCEL, clock_now, 16'(k), 0, 0);
        send_item(FUNC_CHECK, clock_now, 0, 0, 0);

        // Random part: mostly a realistic mix on a moving clock, with bursts
        // that fill the heap and a few unknown operations as noise.
        while (sent < 500) begin
            advance_time();
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                repeat ($urandom_range(20, 66))
                    send_item(FUNC_SCHED, clock_now, pick_id(), pick_interval(),
                              pick_reps());
            end else if (pick < 45) begin
                send_item(FUNC_SCHED, clock_now, pick_id(), pick_interval(), pick_reps());
            end else if (pick < 60) begin
                send_item(FUNC_CANCEL, clock_now, pick_id(), $urandom, 16'($urandom));
            end else if (pick < 97) begin
                send_item(FUNC_CHECK, clock_now, 16'($urandom), $urandom, 16'($urandom));
            end else begin
                send_item(FUNC_NONE, $urandom, 16'($urandom), $urandom, 16'($urandom));
            end
        end
        i_valid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("timer_heap_scheduler test passed");
        else
            $display("timer_heap_scheduler test failed");
        $finish;
    end
endmodule

>>> filelist.f
design/ths_pkg.sv
design/timer_heap_scheduler.sv
tb/timer_heap_scheduler_tb.sv
